// ===== rtl/core/spl_pkg.sv =====
// ============================================================================
// spl_pkg
// Shared constants, types and small arithmetic helpers of the spiking
// pooling layer.
// ============================================================================
package spl_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int CHANNELS   = 4;
    localparam int MAPS       = 4;
    localparam int MAX_POOL   = 4;
    localparam int COUNT_BITS = 16;

    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int YW       = $clog2(MAX_HEIGHT);
    localparam int CHW      = $clog2(CHANNELS);
    localparam int MW       = $clog2(MAPS);
    localparam int IN_DEPTH = CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int PL_DEPTH = MAPS * MAX_HEIGHT * MAX_WIDTH;
    localparam int IAW      = $clog2(IN_DEPTH);
    localparam int PAW      = $clog2(PL_DEPTH);
    localparam int WIDX_W   = 13;
    localparam int NW       = 7;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    // register indexes of the configuration port
    localparam logic [2:0] REG_POOL_W  = 3'd0;
    localparam logic [2:0] REG_POOL_H  = 3'd1;
    localparam logic [2:0] REG_STR_X   = 3'd2;
    localparam logic [2:0] REG_STR_Y   = 3'd3;
    localparam logic [2:0] REG_IN_W    = 3'd4;
    localparam logic [2:0] REG_IN_H    = 3'd5;
    localparam logic [2:0] REG_MODE    = 3'd6;
    localparam logic [2:0] REG_MASK    = 3'd7;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    typedef struct packed {
        logic signed [COUNT_BITS-1:0] emitted;
        logic                         win_valid;
        logic [WIDX_W-1:0]            win_idx;
        logic                         written;
        logic signed [COUNT_BITS-1:0] level;
    } t_pool_entry;

    localparam int PE_W = $bits(t_pool_entry);

    typedef struct packed {
        logic        fire;
        logic        neg;
        logic        we;
        t_pool_entry entry;
    } t_pool_result;

    // step a counter by one with saturation
    function automatic logic signed [COUNT_BITS-1:0] sat_step(
        input logic signed [COUNT_BITS-1:0] v, input logic dec);
        logic signed [COUNT_BITS-1:0] r;
        if (dec) r = (v == CNT_MIN) ? v : v - 1'b1;
        else     r = (v == CNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    // quotient of a value below 40 by a divisor 1..7: reciprocal multiply
    function automatic logic [5:0] div_small(input logic [5:0] v, input logic [2:0] d);
        logic [8:0]  r;
        logic [14:0] prod;
        case (d)
            3'd1:    r = 9'd256;
            3'd2:    r = 9'd128;
            3'd3:    r = 9'd86;
            3'd4:    r = 9'd64;
            3'd5:    r = 9'd52;
            3'd6:    r = 9'd43;
            3'd7:    r = 9'd37;
            default: r = 9'd256;
        endcase
        prod = 15'(v) * 15'(r);
        return prod[13:8];
    endfunction

endpackage

// ===== rtl/core/spl_ram.sv =====
// ============================================================================
// spl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module spl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/spl_pool_alu.sv =====
// ============================================================================
// spl_pool_alu
// Update rule of one pooled output: approximate winner rule in max mode,
// rounded mean threshold in average mode.
// ============================================================================
module spl_pool_alu (
    input  spl_pkg::t_pool_entry                  i_entry,
    input  logic                                  i_mode,
    input  logic signed [spl_pkg::COUNT_BITS-1:0] i_act,
    input  logic                                  i_neg,
    input  logic [spl_pkg::WIDX_W-1:0]            i_widx,
    input  logic [spl_pkg::NW-1:0]                i_n,
    output spl_pkg::t_pool_result                 o_res
);
    import spl_pkg::*;

    logic signed [COUNT_BITS-1:0] max_p;
    logic signed [COUNT_BITS-1:0] avg_p;
    logic [COUNT_BITS:0]          abs_p;
    logic [COUNT_BITS:0]          abs_e;
    logic [COUNT_BITS+2:0]        lhs;
    logic [COUNT_BITS+NW+2:0]     rhs;
    logic                         max_fire;
    logic                         avg_fire;

    always_comb begin
        max_p = i_entry.written ? i_entry.level : CNT_MIN;
        max_fire = (i_act > max_p) ||
                   ((!i_entry.win_valid || i_entry.win_idx == i_widx) && (i_act < max_p));

        avg_p = sat_step(i_entry.written ? i_entry.level : '0, i_neg);
        abs_p = avg_p[COUNT_BITS-1] ? (COUNT_BITS+1)'(-$signed({avg_p[COUNT_BITS-1], avg_p}))
                                    : {1'b0, avg_p};
        abs_e = i_entry.emitted[COUNT_BITS-1]
              ? (COUNT_BITS+1)'(-$signed({i_entry.emitted[COUNT_BITS-1], i_entry.emitted}))
              : {1'b0, i_entry.emitted};
        // round(|p|/n) > |e|  <=>  2|p| + n >= 2n(|e|+1)
        lhs = {1'b0, abs_p, 1'b0} + (COUNT_BITS+3)'(i_n);
        rhs = {(COUNT_BITS+NW+2)'(i_n) * (COUNT_BITS+NW+2)'(abs_e + 1'b1), 1'b0};
        avg_fire = (COUNT_BITS+NW+3)'(lhs) >= rhs;

        o_res = '0;
        o_res.entry = i_entry;
        if (i_mode == MODE_MAX) begin
            o_res.fire = max_fire;
            o_res.neg  = i_act < max_p;
            o_res.we   = max_fire;
            if (max_fire) begin
                o_res.entry.level     = i_act;
                o_res.entry.written   = 1'b1;
                o_res.entry.win_idx   = i_widx;
                o_res.entry.win_valid = 1'b1;
            end
        end else begin
            o_res.fire          = avg_fire;
            o_res.neg           = avg_p[COUNT_BITS-1];
            o_res.we            = 1'b1;
            o_res.entry.level   = avg_p;
            o_res.entry.written = 1'b1;
            if (avg_fire) begin
                o_res.entry.emitted = sat_step(i_entry.emitted, avg_p[COUNT_BITS-1]);
            end
        end
    end
endmodule

// ===== rtl/core/spiking_pool_layer.sv =====
// ============================================================================
// spiking_pool_layer
// Event-driven spiking max / average pooling over four input channels and
// four output maps, with per-pixel and per-output state held in RAM.
// ============================================================================
//
//  channel   dir  carries                                    done when
//  s_axis    in   one input spike {neg, channel, y, x}      tvalid & tready
//  m_axis    out  one pooled spike {neg, y, x, map}, tlast  tvalid & tready
//  cfg       in   register write, index 0..7                 i_cfg_we
//
//  After reset a clearing pass zeroes both RAMs; no input is taken
//  meanwhile (configuration writes are). An item then takes an accept
//  step, a read-modify-write of the activity counter, a scan step for
//  each (window, map) candidate that is skipped, a pool RAM read and a
//  pool RAM write for each one that is used, and a flush step. The
//  output register stalls the walk only when a spike fires while one
//  spike is held and another still waits at m_axis.
//
module spiking_pool_layer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // in_x[4:0], in_y[9:5], in_channel[11:10],
                                        // in_negative[12], zero[15:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_map[1:0], out_x[6:2], out_y[11:7],
                                        // out_negative[12], zero[15:13]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import spl_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CNT   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_POOL  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    // configuration
    logic [2:0]  r_pool_w, r_pool_h, r_str_x, r_str_y;
    logic [5:0]  r_in_w, r_in_h;
    logic        r_mode;
    logic [15:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_w <= 3'd2;
            r_pool_h <= 3'd2;
            r_str_x  <= 3'd2;
            r_str_y  <= 3'd2;
            r_in_w   <= 6'd32;
            r_in_h   <= 6'd32;
            r_mode   <= MODE_MAX;
            r_mask   <= 16'd33825;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POOL_W: r_pool_w <= i_cfg_data[2:0];
                REG_POOL_H: r_pool_h <= i_cfg_data[2:0];
                REG_STR_X:  r_str_x  <= i_cfg_data[2:0];
                REG_STR_Y:  r_str_y  <= i_cfg_data[2:0];
                REG_IN_W:   r_in_w   <= i_cfg_data[5:0];
                REG_IN_H:   r_in_h   <= i_cfg_data[5:0];
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_MASK:   r_mask   <= i_cfg_data;
                default:    r_mask   <= r_mask;
            endcase
        end
    end

    // effective geometry: zero acts as one, oversize clamps to the maximum
    logic [5:0] eff_w, eff_h;
    logic [2:0] eff_p, eff_q, eff_s, eff_t;
    logic [5:0] nx, ny;
    logic [4:0] pq;
    logic [10:0] wh;

    always_comb begin
        eff_w = (r_in_w == '0) ? 6'd1 : ((r_in_w > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : r_in_w);
        eff_h = (r_in_h == '0) ? 6'd1 : ((r_in_h > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : r_in_h);
        eff_p = (r_pool_w == '0) ? 3'd1 : ((r_pool_w > 3'(MAX_POOL)) ? 3'(MAX_POOL) : r_pool_w);
        eff_q = (r_pool_h == '0) ? 3'd1 : ((r_pool_h > 3'(MAX_POOL)) ? 3'(MAX_POOL) : r_pool_h);
        eff_s = (r_str_x == '0) ? 3'd1 : r_str_x;
        eff_t = (r_str_y == '0) ? 3'd1 : r_str_y;
        // number of whole windows along each axis
        nx = ((eff_w + 6'(eff_s)) >= 6'(eff_p))
           ? div_small(eff_w + 6'(eff_s) - 6'(eff_p), eff_s) : 6'd0;
        ny = ((eff_h + 6'(eff_t)) >= 6'(eff_q))
           ? div_small(eff_h + 6'(eff_t) - 6'(eff_q), eff_t) : 6'd0;
        pq = 5'(eff_p) * 5'(eff_q);
        wh = 11'(eff_w) * 11'(eff_h);
    end

    // control state and item registers
    logic [2:0]           r_state, n_state;
    logic [IAW-1:0]       r_clr;
    logic [XW-1:0]        r_x;
    logic [YW-1:0]        r_y;
    logic [CHW-1:0]       r_ch;
    logic                 r_neg;
    logic signed [COUNT_BITS-1:0] r_act;
    logic [WIDX_W-1:0]    r_widx;
    logic [3:0]           r_sx, r_sy, r_sx0;
    logic [XW-1:0]        r_ox, r_ox0;
    logic [YW-1:0]        r_oy;
    logic [MW-1:0]        r_m;
    logic [2:0]           r_sxmax, r_symax;
    logic [NW-1:0]        r_n;

    // held result (last flag unknown yet) and output register
    logic                 r_hv;
    logic [MW-1:0]        r_h_map;
    logic [XW-1:0]        r_h_x;
    logic [YW-1:0]        r_h_y;
    logic                 r_h_neg;
    logic                 r_ov;
    logic [MW-1:0]        r_o_map;
    logic [XW-1:0]        r_o_x;
    logic [YW-1:0]        r_o_y;
    logic                 r_o_neg;
    logic                 r_o_last;

    logic [XW-1:0]  in_x;
    logic [YW-1:0]  in_y;
    logic [CHW-1:0] in_ch;
    logic           in_neg;
    logic           in_acc;
    logic           in_ok;

    assign in_x   = s_axis_tdata[4:0];
    assign in_y   = s_axis_tdata[9:5];
    assign in_ch  = s_axis_tdata[11:10];
    assign in_neg = s_axis_tdata[12];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_ok  = (6'(in_x) < eff_w) && (6'(in_y) < eff_h);

    // input counter RAM
    logic                         ic_we, ic_re;
    logic [IAW-1:0]               ic_waddr, ic_raddr;
    logic [COUNT_BITS-1:0]        ic_wdata, ic_rdata;
    logic signed [COUNT_BITS-1:0] act_new;

    assign act_new = sat_step($signed(ic_rdata), r_neg);

    always_comb begin
        ic_re    = in_acc;
        ic_raddr = {in_ch, in_y, in_x};
        ic_we    = 1'b0;
        ic_waddr = {r_ch, r_y, r_x};
        ic_wdata = act_new;
        if (r_state == S_CLEAR) begin
            ic_we    = 1'b1;
            ic_waddr = r_clr;
            ic_wdata = '0;
        end else if (r_state == S_CNT) begin
            ic_we = 1'b1;
        end
    end

    spl_ram #(.WIDTH(COUNT_BITS), .DEPTH(IN_DEPTH)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (ic_we),
        .i_waddr (ic_waddr),
        .i_wdata (ic_wdata),
        .i_re    (ic_re),
        .i_raddr (ic_raddr),
        .o_rdata (ic_rdata)
    );

    // window walk: first window offsets of the pixel
    logic [5:0]  oy0_q, ox0_q;
    logic [7:0]  sy0_full, sx0_full;
    logic [3:0]  sx0, sy0;
    logic [5:0]  x1, y1;
    logic [2:0]  sxmax, symax;
    logic [WIDX_W-1:0] widx;

    always_comb begin
        ox0_q    = div_small({1'b0, r_x}, eff_s);
        oy0_q    = div_small({1'b0, r_y}, eff_t);
        sx0_full = 8'(r_x) - 8'(ox0_q[XW-1:0]) * 8'(eff_s);
        sy0_full = 8'(r_y) - 8'(oy0_q[YW-1:0]) * 8'(eff_t);
        sx0      = sx0_full[3:0];
        sy0      = sy0_full[3:0];
        x1       = 6'(r_x) + 6'd1;
        y1       = 6'(r_y) + 6'd1;
        sxmax    = (x1 < 6'(eff_p)) ? x1[2:0] : eff_p;
        symax    = (y1 < 6'(eff_q)) ? y1[2:0] : eff_q;
        widx     = WIDX_W'(r_x) + WIDX_W'(eff_w) * WIDX_W'(r_y)
                 + WIDX_W'(r_ch) * WIDX_W'(wh);
    end

    // candidate test and step to the next (sy, sx, map)
    logic          conn;
    logic          cand_ok;
    logic [3:0]    nsx, nsy;
    logic          last_m, x_wrap, walk_done;
    logic [2:0]    map_cnt;
    logic [NW-1:0] n_cand;

    always_comb begin
        conn    = r_mask[{r_ch, r_m}];
        cand_ok = conn && (6'(r_ox) < nx) && (6'(r_oy) < ny);
        nsx     = r_sx + 4'(eff_s);
        nsy     = r_sy + 4'(eff_t);
        last_m  = (r_m == MW'(MAPS - 1));
        x_wrap  = (nsx >= 4'(r_sxmax));
        walk_done = last_m && x_wrap && (nsy >= 4'(r_symax));
        map_cnt = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            map_cnt = map_cnt + 3'(r_mask[c * MAPS + int'(r_m)]);
        end
        n_cand = NW'(pq) * NW'(map_cnt);
    end

    // pool RAM and its update rule
    logic                 pl_we, pl_re;
    logic [PAW-1:0]       pl_waddr, pl_raddr;
    logic [PE_W-1:0]      pl_wdata, pl_rdata;
    t_pool_result         res;
    logic                 out_free;
    logic                 pool_stall;

    assign out_free   = !r_ov || m_axis_tready;
    assign pool_stall = res.fire && r_hv && !out_free;

    spl_pool_alu u_alu (
        .i_entry (t_pool_entry'(pl_rdata)),
        .i_mode  (r_mode),
        .i_act   (r_act),
        .i_neg   (r_neg),
        .i_widx  (r_widx),
        .i_n     (r_n),
        .o_res   (res)
    );

    always_comb begin
        pl_re    = (r_state == S_SCAN) && cand_ok;
        pl_raddr = {r_m, r_oy, r_ox};
        pl_we    = 1'b0;
        pl_waddr = {r_m, r_oy, r_ox};
        pl_wdata = res.entry;
        if (r_state == S_CLEAR) begin
            pl_we    = 1'b1;
            pl_waddr = PAW'(r_clr);
            pl_wdata = '0;
        end else if (r_state == S_POOL) begin
            pl_we = res.we && !pool_stall;
        end
    end

    spl_ram #(.WIDTH(PE_W), .DEPTH(PL_DEPTH)) u_pool_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == IAW'(IN_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_acc && in_ok) n_state = S_CNT;
            S_CNT: begin
                if ((sx0 >= 4'(sxmax)) || (sy0 >= 4'(symax))) n_state = S_FLUSH;
                else                                         n_state = S_SCAN;
            end
            S_SCAN: begin
                if (cand_ok)        n_state = S_POOL;
                else if (walk_done) n_state = S_FLUSH;
            end
            S_POOL: begin
                if (!pool_stall) n_state = walk_done ? S_FLUSH : S_SCAN;
            end
            S_FLUSH: if (!r_hv || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic advance;
    logic n_ov;
    assign advance = ((r_state == S_SCAN) && !cand_ok) ||
                     ((r_state == S_POOL) && !pool_stall);

    // output register: drain on a completed transaction, load when a new
    // spike pushes the held one out or the walk ends with one held
    always_comb begin
        n_ov = r_ov && !m_axis_tready;
        if ((r_state == S_POOL) && res.fire && !pool_stall && r_hv) begin
            n_ov = 1'b1;
        end
        if ((r_state == S_FLUSH) && r_hv && out_free) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // a new spike pushes the held one out, not last
            if ((r_state == S_POOL) && res.fire && !pool_stall) begin
                r_hv <= 1'b1;
            end
            // end of walk: the held spike is the last one of the item
            if ((r_state == S_FLUSH) && r_hv && out_free) begin
                r_hv <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= in_x;
            r_y   <= in_y;
            r_ch  <= in_ch;
            r_neg <= in_neg;
        end
        if (r_state == S_CNT) begin
            r_act   <= act_new;
            r_widx  <= widx;
            r_sx    <= sx0;
            r_sx0   <= sx0;
            r_sy    <= sy0;
            r_ox    <= ox0_q[XW-1:0];
            r_ox0   <= ox0_q[XW-1:0];
            r_oy    <= oy0_q[YW-1:0];
            r_m     <= '0;
            r_sxmax <= sxmax;
            r_symax <= symax;
        end
        if ((r_state == S_SCAN) && cand_ok) begin
            r_n <= n_cand;
        end
        if (advance) begin
            if (!last_m) begin
                r_m <= r_m + 1'b1;
            end else begin
                r_m <= '0;
                if (!x_wrap) begin
                    r_sx <= nsx;
                    r_ox <= r_ox - 1'b1;
                end else begin
                    r_sx <= r_sx0;
                    r_ox <= r_ox0;
                    r_sy <= nsy;
                    r_oy <= r_oy - 1'b1;
                end
            end
        end
        if ((r_state == S_POOL) && res.fire && !pool_stall) begin
            r_h_map <= r_m;
            r_h_x   <= r_ox;
            r_h_y   <= r_oy;
            r_h_neg <= res.neg;
            if (r_hv) begin
                r_o_map  <= r_h_map;
                r_o_x    <= r_h_x;
                r_o_y    <= r_h_y;
                r_o_neg  <= r_h_neg;
                r_o_last <= 1'b0;
            end
        end
        if ((r_state == S_FLUSH) && r_hv && out_free) begin
            r_o_map  <= r_h_map;
            r_o_x    <= r_h_x;
            r_o_y    <= r_h_y;
            r_o_neg  <= r_h_neg;
            r_o_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b000, r_o_neg, r_o_y, r_o_x, r_o_map};
    assign m_axis_tlast  = r_o_last;

    // a new item starts only with no spike held back
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_hv)
        else $error("input taken while a pooled spike is still held");

    // no output while the RAMs are being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_ov && !r_hv)
        else $error("output activity during the clearing pass");

    // pool RAM writes only on a clearing step or a pool update
    a_pool_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pl_we |-> (r_state == S_CLEAR) || (r_state == S_POOL))
        else $error("pool RAM written outside an update");

    // a pool update always follows a read of the same candidate
    a_pool_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POOL) && !$past(r_state == S_POOL) |-> $past(pl_re))
        else $error("pool update without a preceding read");
endmodule
